// ----- src/bbdf_pkg.sv -----
package bbdf_pkg;

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_LEN  = 3'd1;
	localparam logic [2:0] PH_HDR  = 3'd2;
	localparam logic [2:0] PH_PAY  = 3'd3;
	localparam logic [2:0] PH_CHK  = 3'd4;
	localparam logic [2:0] PH_CR   = 3'd5;
	localparam logic [2:0] PH_LF   = 3'd6;

	localparam logic [7:0] SYNC_BYTE = 8'h42;
	localparam logic [7:0] CR_BYTE   = 8'h0D;
	localparam logic [7:0] LF_BYTE   = 8'h0A;

	localparam logic [15:0] HDR_LEN      = 16'd43;
	localparam logic [5:0]  HDR_LAST_POS = 6'd42;
	localparam logic [5:0]  CMD_HI_POS   = 6'd31;
	localparam logic [5:0]  CMD_LO_POS   = 6'd32;

	localparam logic [15:0] FWD_CMD_RST = 16'h0081;

	typedef logic [7:0] byte_t;

endpackage

// ----- src/bb_frame_deframer_core.sv -----
// Receive deframer for 'B''B' frames. Takes one byte per cycle on the in channel;
// the payload is buffered in a MAX_PAYLOAD-entry RAM (one write and one read port)
// and read out one registered word per cycle on the out channel while out_ready allows, once the
// LF byte of a forwarded frame is taken. Input and output run concurrently:
// the input stalls only while a readout is in progress and either a new payload
// byte would land on a buffer entry not yet read, or a new frame's LF arrives
// before the previous readout has been fully issued. Output words carry last on
// the final payload byte, check_ok for the XOR check, and overflow if an oversized
// frame was dropped since the previous forwarded frame.
module bb_frame_deframer_core #(
	parameter int MAX_PAYLOAD = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [15:0]          cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bbdf_pkg::byte_t      rx_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bbdf_pkg::byte_t      out_byte,
	output logic                 last,
	output logic                 check_ok,
	output logic                 overflow
);

	import bbdf_pkg::*;

	localparam int CW = $clog2(MAX_PAYLOAD + 1);
	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	logic [15:0]   fwd_cmd_q;
	logic [2:0]    phase_q;
	logic          prev_b_q;
	logic [5:0]    pos_q;
	byte_t         flen_q;
	logic [15:0]   cmd_q;
	byte_t         xor_q;
	byte_t         rx_check_q;
	logic [CW-1:0] plen_q;
	logic [CW-1:0] count_q;
	logic          ovf_seen_q;

	logic [CW-1:0] rd_ptr_q;
	logic [CW-1:0] drain_len_q;
	logic          drain_ok_q;
	logic          drain_ov_q;

	logic          s1_valid_s1;
	logic          s1_last_s1;
	logic          s1_ok_s1;
	logic          s1_ov_s1;

	logic          out_valid_q;
	byte_t         out_byte_q;
	logic          out_last_q;
	logic          out_ok_q;
	logic          out_ov_q;

	logic          in_acc;
	logic          draining;
	logic          emit_go;
	logic          out_free;
	logic          rd_issue;
	logic          s1_adv;
	logic          ram_we;
	byte_t         ram_rd_data;
	logic [15:0]   flen_next;
	logic [15:0]   plen16;
	logic [CW-1:0] count_inc;

	assign draining  = (rd_ptr_q != drain_len_q);
	assign emit_go   = (rx_byte == LF_BYTE) && (cmd_q == fwd_cmd_q) && (count_q != '0);
	assign in_ready  = !(draining && (((phase_q == PH_PAY) && !(count_q < rd_ptr_q))
		|| (phase_q == PH_LF)));
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign rd_issue  = draining && (!s1_valid_s1 || out_free);
	assign s1_adv    = s1_valid_s1 && out_free;
	assign ram_we    = in_acc && (phase_q == PH_PAY);
	assign flen_next = {flen_q, rx_byte};
	assign plen16    = flen_next - HDR_LEN;
	assign count_inc = count_q + CW'(1);

	bbdf_ram #(
		.WIDTH(8),
		.DEPTH(MAX_PAYLOAD)
	) u_buf (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (rx_byte),
		.rd_en   (rd_issue),
		.rd_addr (rd_ptr_q[AW-1:0]),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_cmd_q <= FWD_CMD_RST;
		end else if (cfg_wr_en) begin
			fwd_cmd_q <= cfg_wr_data;
		end
	end

	// frame parser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			prev_b_q   <= 1'b0;
			pos_q      <= '0;
			flen_q     <= '0;
			cmd_q      <= '0;
			xor_q      <= '0;
			rx_check_q <= '0;
			plen_q     <= '0;
			count_q    <= '0;
			ovf_seen_q <= 1'b0;
		end else if (in_acc) begin
			unique case (phase_q)
				PH_LEN: begin
					xor_q  <= xor_q ^ rx_byte;
					flen_q <= rx_byte;
					pos_q  <= pos_q + 6'd1;
					if (pos_q != '0) begin
						pos_q <= '0;
						if (flen_next < HDR_LEN) begin
							phase_q  <= PH_HUNT;
							prev_b_q <= 1'b0;
						end else if (plen16 > 16'(MAX_PAYLOAD)) begin
							ovf_seen_q <= 1'b1;
							phase_q    <= PH_HUNT;
							prev_b_q   <= 1'b0;
						end else begin
							phase_q <= PH_HDR;
							plen_q  <= plen16[CW-1:0];
						end
					end
				end
				PH_HDR: begin
					xor_q <= xor_q ^ rx_byte;
					if (pos_q == CMD_HI_POS || pos_q == CMD_LO_POS) begin
						cmd_q <= {cmd_q[7:0], rx_byte};
					end
					pos_q <= pos_q + 6'd1;
					if (pos_q == HDR_LAST_POS) begin
						pos_q   <= '0;
						phase_q <= (plen_q == '0) ? PH_CHK : PH_PAY;
					end
				end
				PH_PAY: begin
					xor_q   <= xor_q ^ rx_byte;
					count_q <= count_inc;
					if (count_inc >= plen_q) begin
						phase_q <= PH_CHK;
					end
				end
				PH_CHK: begin
					rx_check_q <= rx_byte;
					phase_q    <= PH_CR;
				end
				PH_CR: begin
					if (rx_byte == CR_BYTE) begin
						phase_q <= PH_LF;
					end else begin
						phase_q  <= PH_HUNT;
						prev_b_q <= 1'b0;
						pos_q    <= '0;
					end
				end
				PH_LF: begin
					if (emit_go) begin
						ovf_seen_q <= 1'b0;
					end
					phase_q  <= PH_HUNT;
					prev_b_q <= 1'b0;
					pos_q    <= '0;
				end
				default: begin
					if (prev_b_q && rx_byte == SYNC_BYTE) begin
						phase_q    <= PH_LEN;
						prev_b_q   <= 1'b0;
						pos_q      <= '0;
						flen_q     <= '0;
						cmd_q      <= '0;
						xor_q      <= '0;
						rx_check_q <= '0;
						count_q    <= '0;
					end else begin
						phase_q  <= PH_HUNT;
						prev_b_q <= (rx_byte == SYNC_BYTE);
					end
				end
			endcase
		end
	end

	// buffer readout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q    <= '0;
			drain_len_q <= '0;
			drain_ok_q  <= 1'b0;
			drain_ov_q  <= 1'b0;
			s1_valid_s1 <= 1'b0;
			s1_last_s1  <= 1'b0;
			s1_ok_s1    <= 1'b0;
			s1_ov_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_ok_q    <= 1'b0;
			out_ov_q    <= 1'b0;
		end else begin
			if (in_acc && phase_q == PH_LF && emit_go) begin
				rd_ptr_q    <= '0;
				drain_len_q <= count_q;
				drain_ok_q  <= (rx_check_q == xor_q);
				drain_ov_q  <= ovf_seen_q;
			end else if (rd_issue) begin
				rd_ptr_q <= rd_ptr_q + CW'(1);
			end

			if (rd_issue) begin
				s1_valid_s1 <= 1'b1;
				s1_last_s1  <= (rd_ptr_q == drain_len_q - CW'(1));
				s1_ok_s1    <= drain_ok_q;
				s1_ov_s1    <= drain_ov_q;
			end else if (s1_adv) begin
				s1_valid_s1 <= 1'b0;
			end

			if (s1_adv) begin
				out_valid_q <= 1'b1;
				out_last_q  <= s1_last_s1;
				out_ok_q    <= s1_ok_s1;
				out_ov_q    <= s1_ov_s1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_byte_q <= ram_rd_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = out_last_q;
	assign check_ok  = out_ok_q;
	assign overflow  = out_ov_q;

`ifndef SYNTHESIS
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_ptr_q <= drain_len_q)
		else $error("read pointer beyond readout length");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && draining) |-> (count_q < rd_ptr_q))
		else $error("payload write on an unread buffer entry");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (count_q < CW'(MAX_PAYLOAD)))
		else $error("payload write beyond buffer");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (draining && (phase_q == PH_PAY || phase_q == PH_LF)))
		else $error("input stalled without a readout conflict");

	a_last_ends_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_issue && rd_ptr_q == drain_len_q - CW'(1)) |=> !draining)
		else $error("readout continues after last word");
`endif

endmodule

// ----- src/bbdf_ram.sv -----
module bbdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import bbdf_pkg::*;

	localparam int PAY_MAX = 64;
	localparam int WATCHDOG = 3000;
	localparam int SETTLE = 8;
	localparam int RAND_BYTES = 50;

	class deframe_scoreboard;
		typedef struct packed {
			byte_t data;
			logic  last;
			logic  ok;
			logic  ovf;
		} out_word_t;

		logic [15:0] fwd_cmd;
		logic [2:0]  ph;
		bit          sync_b;
		logic [15:0] pos;
		logic [15:0] flen;
		logic [15:0] code;
		byte_t       xsum;
		byte_t       rcheck;
		byte_t       store [PAY_MAX];
		logic [6:0]  pcount;
		bit          ovf_pend;
		out_word_t   words_q[$];
		int          errors;

		function new();
			fwd_cmd = FWD_CMD_RST;
			ph = PH_HUNT;
			sync_b = 0;
			pos = '0;
			flen = '0;
			code = '0;
			xsum = '0;
			rcheck = '0;
			pcount = '0;
			ovf_pend = 0;
			errors = 0;
		endfunction

		function void restart();
			ph = PH_HUNT;
			sync_b = 0;
			pos = '0;
		endfunction

		function void take_rx_byte(byte_t b);
			out_word_t w;
			int n;
			case (ph)
				PH_LEN: begin
					xsum ^= b;
					flen = {flen[7:0], b};
					pos++;
					if (pos >= 2) begin
						if (flen < HDR_LEN) begin
							restart();
						end else if (int'(flen - HDR_LEN) > PAY_MAX) begin
							ovf_pend = 1;
							restart();
						end else begin
							ph = PH_HDR;
							pos = '0;
						end
					end
				end
				PH_HDR: begin
					xsum ^= b;
					if (pos == CMD_HI_POS || pos == CMD_LO_POS)
						code = {code[7:0], b};
					pos++;
					if (pos >= HDR_LEN) begin
						pos = '0;
						ph = (flen == HDR_LEN) ? PH_CHK : PH_PAY;
					end
				end
				PH_PAY: begin
					xsum ^= b;
					store[pcount[5:0]] = b;
					pcount = pcount + 7'd1;
					if ({9'd0, pcount} >= flen - HDR_LEN)
						ph = PH_CHK;
				end
				PH_CHK: begin
					rcheck = b;
					ph = PH_CR;
				end
				PH_CR: begin
					if (b == CR_BYTE)
						ph = PH_LF;
					else
						restart();
				end
				PH_LF: begin
					if (b == LF_BYTE && code == fwd_cmd && pcount != 0) begin
						n = (int'(pcount) > PAY_MAX) ? PAY_MAX : int'(pcount);
						for (int k = 0; k < n; k++) begin
							w.data = store[k];
							w.last = (k == n - 1);
							w.ok = (rcheck == xsum);
							w.ovf = ovf_pend;
							words_q.push_back(w);
						end
						ovf_pend = 0;
					end
					restart();
				end
				default: begin
					if (sync_b && b == SYNC_BYTE) begin
						ph = PH_LEN;
						sync_b = 0;
						pos = '0;
						flen = '0;
						code = '0;
						xsum = '0;
						rcheck = '0;
						pcount = '0;
					end else begin
						ph = PH_HUNT;
						sync_b = (b == SYNC_BYTE);
					end
				end
			endcase
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_out_word(byte_t d, logic l, logic ok, logic ov);
			out_word_t w;
			if (words_q.size() == 0) begin
				report_mismatch($sformatf("word %h with none pending", d));
				return;
			end
			w = words_q.pop_front();
			if (d !== w.data)
				report_mismatch($sformatf("out_byte %h, want %h", d, w.data));
			if (l !== w.last)
				report_mismatch($sformatf("last %b, want %b", l, w.last));
			if (ok !== w.ok)
				report_mismatch($sformatf("check_ok %b, want %b", ok, w.ok));
			if (ov !== w.ovf)
				report_mismatch($sformatf("overflow %b, want %b", ov, w.ovf));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	byte_t       rx_byte;
	logic        out_valid;
	logic        out_ready;
	byte_t       out_byte;
	logic        last;
	logic        check_ok;
	logic        overflow;

	deframe_scoreboard sb = new();

	bit          src_gaps = 1;
	bit          sink_stalls = 1;
	int          hold_left = 0;
	int          stall_left = 0;
	int          idle_cycles = 0;
	int          frame_bytes = 0;
	logic [15:0] cur_cmd = FWD_CMD_RST;

	bb_frame_deframer_core #(.MAX_PAYLOAD(PAY_MAX)) u_top (
		.clk,
		.arst_n,
		.cfg_wr_en,
		.cfg_wr_data,
		.in_valid,
		.in_ready,
		.rx_byte,
		.out_valid,
		.out_ready,
		.out_byte,
		.last,
		.check_ok,
		.overflow
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int gap_len(bit on);
		int r;
		if (!on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.take_rx_byte(rx_byte);
		if (out_valid && out_ready)
			sb.check_out_word(out_byte, last, check_ok, overflow);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				stall_left = gap_len(sink_stalls);
				out_ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	task automatic send_byte(byte_t b);
		int g;
		g = gap_len(src_gaps);
		@(negedge clk);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_frame(logic [15:0] code, byte_t pay[$], bit bad_chk, byte_t cr,
			byte_t lf);
		byte_t       q[$];
		byte_t       sum;
		byte_t       h;
		logic [15:0] len_f;
		len_f = HDR_LEN + 16'(pay.size());
		q.push_back(SYNC_BYTE);
		q.push_back(SYNC_BYTE);
		q.push_back(len_f[15:8]);
		q.push_back(len_f[7:0]);
		sum = len_f[15:8] ^ len_f[7:0];
		for (int k = 0; k < int'(HDR_LEN); k++) begin
			if (k == int'(CMD_HI_POS))
				h = code[15:8];
			else if (k == int'(CMD_LO_POS))
				h = code[7:0];
			else
				h = byte_t'($urandom);
			sum ^= h;
			q.push_back(h);
		end
		foreach (pay[k]) begin
			sum ^= pay[k];
			q.push_back(pay[k]);
		end
		if (bad_chk)
			sum ^= byte_t'($urandom_range(1, 255));
		q.push_back(sum);
		q.push_back(cr);
		q.push_back(lf);
		foreach (q[k])
			send_byte(q[k]);
		frame_bytes += q.size();
	endtask

	task automatic send_dropped(logic [15:0] len_f);
		send_byte(SYNC_BYTE);
		send_byte(SYNC_BYTE);
		send_byte(len_f[15:8]);
		send_byte(len_f[7:0]);
		frame_bytes += 4;
	endtask

	function automatic void fill_random(output byte_t q[$], input int n);
		q.delete();
		repeat (n) q.push_back(byte_t'($urandom));
	endfunction

	function automatic byte_t other_than(byte_t x);
		byte_t b;
		do b = byte_t'($urandom); while (b == x);
		return b;
	endfunction

	function automatic int pay_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 8);
		if (r < 94)
			return $urandom_range(9, PAY_MAX - 1);
		return PAY_MAX;
	endfunction

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.words_q.size() != 0 || hold_left != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cmd(logic [15:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.fwd_cmd = v;
		cur_cmd = v;
	endtask

	task automatic run_random_frame();
		int    r;
		int    n;
		byte_t pay[$];
		r = $urandom_range(0, 99);
		fill_random(pay, pay_size());
		if (r < 55) begin
			send_frame(cur_cmd, pay, 0, CR_BYTE, LF_BYTE);
		end else if (r < 63) begin
			send_frame(cur_cmd, pay, 1, CR_BYTE, LF_BYTE);
		end else if (r < 70) begin
			send_frame(cur_cmd ^ 16'($urandom_range(1, 65535)), pay, 0, CR_BYTE, LF_BYTE);
		end else if (r < 74) begin
			pay.delete();
			send_frame(cur_cmd, pay, 1'($urandom_range(0, 1)), CR_BYTE, LF_BYTE);
		end else if (r < 79) begin
			send_frame(cur_cmd, pay, 0, other_than(CR_BYTE), LF_BYTE);
		end else if (r < 84) begin
			send_frame(cur_cmd, pay, 0, CR_BYTE, other_than(LF_BYTE));
		end else if (r < 88) begin
			send_dropped(16'($urandom_range(0, 42)));
		end else if (r < 91) begin
			send_dropped(16'($urandom_range(108, 200)));
		end else if (r < 93) begin
			send_dropped(16'($urandom_range(201, 65535)));
		end else begin
			n = $urandom_range(1, 10);
			repeat (n) send_byte(($urandom_range(0, 2) == 0) ? SYNC_BYTE : byte_t'($urandom));
		end
	endtask

	initial begin
		byte_t       pay[$];
		int          bytes_start;
		int          idx;
		logic [15:0] v;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// reset command value, never written yet
		pay.delete();
		for (int k = 0; k < PAY_MAX; k++)
			pay.push_back((k % 4 == 0) ? 8'hFF : (k % 4 == 1) ? 8'h00 :
				(k % 4 == 2) ? 8'hA5 : 8'h5A);
		send_frame(cur_cmd, pay, 0, CR_BYTE, LF_BYTE);
		send_dropped(16'd108);
		send_dropped(16'd42);
		pay.delete();
		send_frame(cur_cmd, pay, 0, CR_BYTE, LF_BYTE);
		wait_drained();

		// output held off while the next frame's payload keeps coming
		hold_left = 150;
		src_gaps = 0;
		fill_random(pay, 3);
		send_frame(cur_cmd, pay, 1, CR_BYTE, LF_BYTE);
		fill_random(pay, 4);
		send_frame(cur_cmd, pay, 0, CR_BYTE, other_than(LF_BYTE));
		src_gaps = 1;
		wait_drained();

		bytes_start = frame_bytes;
		idx = 0;
		while (frame_bytes - bytes_start < RAND_BYTES) begin
			case (idx % 4)
				0: v = 16'h0000;
				1: v = 16'hFFFF;
				2: v = 16'($urandom);
				default: v = FWD_CMD_RST;
			endcase
			wait_drained();
			write_cmd(v);
			src_gaps = ($urandom_range(0, 3) != 0);
			sink_stalls = ($urandom_range(0, 3) != 0);
			run_random_frame();
			idx++;
		end
		wait_drained();

		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
